// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the block's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LBC_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbc: same-cycle check failed");

// Next-cycle implication.
`define LBC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbc: next-cycle check failed");

`endif

// ----- hdl/lbc_pkg.sv -----
// Shared types and constants of the block cache tag engine.
`default_nettype none

package lbc_pkg;

    localparam int LBA_W     = 32;
    localparam int STAMP_W   = 32;
    localparam int WAY_OUT_W = 2;
    localparam int SLOT_W    = 4;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_FILL   = 1'b1;

    // Outcome of the way selection for one request.
    typedef struct packed {
        logic hit;
        logic wr;
    } t_sel;

endpackage

`default_nettype wire

// ----- hdl/lbc_ifs.sv -----
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface lbc_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [lbc_pkg::LBA_W-1:0] lba;

    modport source (output valid, output req_type, output lba, input ready);
    modport sink   (input valid, input req_type, input lba, output ready);
endinterface

interface lbc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [lbc_pkg::WAY_OUT_W-1:0] way;
    logic [lbc_pkg::SLOT_W-1:0]    slot;

    modport source (output valid, output hit, output way, output slot, input ready);
    modport sink   (input valid, input hit, input way, input slot, output ready);
endinterface

`default_nettype wire

// ----- hdl/lba_block_cache_tags_core.sv -----
// Top level of the block cache tag and replacement engine.
// The set row is read into a register at accept; the select result is then registered.
// Throughput: one request beat per cycle while responses are taken, set by the row store
// with one read and one write port, read at accept and written back when the request
// leaves the select stage. Reset: synchronous, active low; afterwards a clearing pass
// zeroes every set row (valid, stamps, set clock), request channel held not ready.
`default_nettype none
`include "assert_macros.svh"

module lba_block_cache_tags_core #(
    parameter int SETS = 4,
    parameter int WAYS = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lbc_req_if.sink    i_req,
    lbc_rsp_if.source  o_rsp
);

    // SETS must be a power of two, which the block does not check: the set is the low LBA bits.
    localparam int SET_BITS = $clog2(SETS);
    localparam int SET_IW   = (SETS > 1) ? SET_BITS : 1;
    localparam int WAY_IW   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W    = lbc_pkg::LBA_W - SET_BITS;
    localparam int SW       = lbc_pkg::STAMP_W;

    // Set row store, one row per set.
    logic [WAYS-1:0]                r_mem_valid [SETS];
    logic [WAYS-1:0][TAG_W-1:0]     r_mem_tags  [SETS];
    logic [WAYS-1:0][SW-1:0]        r_mem_stamp [SETS];
    logic [SW-1:0]                  r_mem_clock [SETS];

    logic [WAYS-1:0]                r_q_valid;
    logic [WAYS-1:0][TAG_W-1:0]     r_q_tags;
    logic [WAYS-1:0][SW-1:0]        r_q_stamp;
    logic [SW-1:0]                  r_q_clock;

    // Row written back in the same cycle as the read of the same set.
    logic                           r_byp;
    logic [WAYS-1:0]                r_byp_valid;
    logic [WAYS-1:0][TAG_W-1:0]     r_byp_tags;
    logic [WAYS-1:0][SW-1:0]        r_byp_stamp;
    logic [SW-1:0]                  r_byp_clock;

    logic                           r_clr_busy;
    logic [SET_IW-1:0]              r_clr_idx;

    logic                           r_s1_valid;
    logic                           r_s1_fill;
    logic [SET_IW-1:0]              r_s1_set;
    logic [TAG_W-1:0]               r_s1_tag;

    logic                           r_out_valid;
    logic                           r_out_hit;
    logic [lbc_pkg::WAY_OUT_W-1:0]  r_out_way;
    logic [lbc_pkg::SLOT_W-1:0]     r_out_slot;

    logic                           w_adv;
    logic                           w_s1_fire;
    logic                           w_ready;
    logic                           w_acc;
    logic [SET_IW-1:0]              w_in_set;
    logic [TAG_W-1:0]               w_in_tag;

    logic [WAYS-1:0]                w_row_valid;
    logic [WAYS-1:0][TAG_W-1:0]     w_row_tags;
    logic [WAYS-1:0][SW-1:0]        w_row_stamp;
    logic [SW-1:0]                  w_row_clock;

    lbc_pkg::t_sel                  w_sel;
    logic [WAY_IW-1:0]              w_way;
    logic [WAYS-1:0]                w_new_valid;
    logic [WAYS-1:0][TAG_W-1:0]     w_new_tags;
    logic [WAYS-1:0][SW-1:0]        w_new_stamp;
    logic [SW-1:0]                  w_new_clock;

    logic                           w_s1_wr;
    logic                           w_byp_hit;
    logic                           w_mem_we;
    logic [SET_IW-1:0]              w_mem_addr;
    logic [31:0]                    w_way_ext;
    logic [31:0]                    w_slot_full;

    generate
        if (SETS > 1) begin : g_set
            assign w_in_set = i_req.lba[SET_IW-1:0];
        end else begin : g_one_set
            assign w_in_set = '0;
        end
    endgenerate

    assign w_in_tag  = i_req.lba[lbc_pkg::LBA_W-1:SET_BITS];

    assign w_adv     = !r_out_valid || o_rsp.ready;
    assign w_s1_fire = r_s1_valid && w_adv;
    assign w_ready   = !r_clr_busy && (!r_s1_valid || w_adv);
    assign w_acc     = i_req.valid && w_ready;
    assign i_req.ready = w_ready;

    assign w_row_valid = r_byp ? r_byp_valid : r_q_valid;
    assign w_row_tags  = r_byp ? r_byp_tags  : r_q_tags;
    assign w_row_stamp = r_byp ? r_byp_stamp : r_q_stamp;
    assign w_row_clock = r_byp ? r_byp_clock : r_q_clock;

    lbc_way_select #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W)
    ) u_sel (
        .i_fill   (r_s1_fill),
        .i_tag    (r_s1_tag),
        .i_valid  (w_row_valid),
        .i_tags   (w_row_tags),
        .i_stamps (w_row_stamp),
        .i_clock  (w_row_clock),
        .o_sel    (w_sel),
        .o_way    (w_way),
        .o_valid  (w_new_valid),
        .o_tags   (w_new_tags),
        .o_stamps (w_new_stamp),
        .o_clock  (w_new_clock)
    );

    assign w_s1_wr    = w_s1_fire && w_sel.wr;
    assign w_byp_hit  = w_s1_wr && (r_s1_set == w_in_set);
    assign w_mem_we   = r_clr_busy || w_s1_wr;
    assign w_mem_addr = r_clr_busy ? r_clr_idx : r_s1_set;

    // Row store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            if (r_clr_busy) begin
                r_mem_valid[w_mem_addr] <= '0;
                r_mem_tags[w_mem_addr]  <= '0;
                r_mem_stamp[w_mem_addr] <= '0;
                r_mem_clock[w_mem_addr] <= '0;
            end else begin
                r_mem_valid[w_mem_addr] <= w_new_valid;
                r_mem_tags[w_mem_addr]  <= w_new_tags;
                r_mem_stamp[w_mem_addr] <= w_new_stamp;
                r_mem_clock[w_mem_addr] <= w_new_clock;
            end
        end
        if (w_acc) begin
            r_q_valid <= r_mem_valid[w_in_set];
            r_q_tags  <= r_mem_tags[w_in_set];
            r_q_stamp <= r_mem_stamp[w_in_set];
            r_q_clock <= r_mem_clock[w_in_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp       <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == SET_IW'(SETS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_acc) begin
                r_byp <= w_byp_hit;
            end
            if (w_ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_fill   <= i_req.req_type;
            r_s1_set    <= w_in_set;
            r_s1_tag    <= w_in_tag;
            r_byp_valid <= w_new_valid;
            r_byp_tags  <= w_new_tags;
            r_byp_stamp <= w_new_stamp;
            r_byp_clock <= w_new_clock;
        end
        if (w_s1_fire) begin
            r_out_hit  <= w_sel.hit;
            r_out_way  <= w_way_ext[lbc_pkg::WAY_OUT_W-1:0];
            r_out_slot <= w_slot_full[lbc_pkg::SLOT_W-1:0];
        end
    end

    assign w_way_ext   = 32'(w_way);
    assign w_slot_full = (32'(r_s1_set) * 32'(WAYS)) + w_way_ext;

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.hit   = r_out_hit;
    assign o_rsp.way   = r_out_way;
    assign o_rsp.slot  = r_out_slot;

    `LBC_ASSERT_IMPLY(a_no_accept_in_clear, i_clk, i_rst_n, r_clr_busy, !i_req.ready)
    `LBC_ASSERT_IMPLY(a_fill_writes, i_clk, i_rst_n, r_s1_valid && r_s1_fill, w_sel.wr)
    `LBC_ASSERT_NEXT(a_fire_fills_out, i_clk, i_rst_n, w_s1_fire, o_rsp.valid)
    `LBC_ASSERT_NEXT(a_byp_after_write, i_clk, i_rst_n, w_acc && w_byp_hit, r_byp)

endmodule

`default_nettype wire

// ----- hdl/lbc_way_select.sv -----
// Hit detection, victim choice and row update for one set.
`default_nettype none

module lbc_way_select #(
    parameter  int WAYS   = 4,
    parameter  int TAG_W  = 30,
    localparam int WAY_IW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  wire logic                                   i_fill,
    input  wire logic [TAG_W-1:0]                       i_tag,
    input  wire logic [WAYS-1:0]                        i_valid,
    input  wire logic [WAYS-1:0][TAG_W-1:0]             i_tags,
    input  wire logic [WAYS-1:0][lbc_pkg::STAMP_W-1:0]  i_stamps,
    input  wire logic [lbc_pkg::STAMP_W-1:0]            i_clock,
    output lbc_pkg::t_sel                               o_sel,
    output logic [WAY_IW-1:0]                           o_way,
    output logic [WAYS-1:0]                             o_valid,
    output logic [WAYS-1:0][TAG_W-1:0]                  o_tags,
    output logic [WAYS-1:0][lbc_pkg::STAMP_W-1:0]       o_stamps,
    output logic [lbc_pkg::STAMP_W-1:0]                 o_clock
);

    logic [WAYS-1:0]   w_match;
    logic [WAYS-1:0]   w_stop;
    logic [WAYS-1:0]   w_lru;
    logic              w_hit_any;
    logic              w_stop_any;
    logic [WAY_IW-1:0] w_hit_way;
    logic [WAY_IW-1:0] w_stop_way;
    logic [WAY_IW-1:0] w_lru_way;

    // Per-way flags; a way is oldest if strictly below every earlier way
    // and no larger than every later one (lowest way wins ties).
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            w_match[w] = i_valid[w] && (i_tags[w] == i_tag);
            w_stop[w]  = w_match[w] || !i_valid[w];
            w_lru[w]   = 1'b1;
            for (int j = 0; j < WAYS; j++) begin
                if (j < w) begin
                    w_lru[w] = w_lru[w] && (i_stamps[w] < i_stamps[j]);
                end else if (j > w) begin
                    w_lru[w] = w_lru[w] && (i_stamps[w] <= i_stamps[j]);
                end
            end
        end
    end

    // Priority encoders: lowest qualifying way.
    always_comb begin
        w_hit_way  = '0;
        w_stop_way = '0;
        w_lru_way  = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_match[w]) begin
                w_hit_way = WAY_IW'(w);
            end
            if (w_stop[w]) begin
                w_stop_way = WAY_IW'(w);
            end
            if (w_lru[w]) begin
                w_lru_way = WAY_IW'(w);
            end
        end
    end

    assign w_hit_any  = |w_match;
    assign w_stop_any = |w_stop;

    always_comb begin
        o_sel    = '0;
        o_way    = '0;
        o_valid  = i_valid;
        o_tags   = i_tags;
        o_stamps = i_stamps;
        o_clock  = i_clock;
        if (i_fill == lbc_pkg::REQ_FILL) begin
            o_sel.wr = 1'b1;
            if (w_stop_any) begin
                o_way     = w_stop_way;
                o_sel.hit = w_match[w_stop_way];
            end else begin
                o_way = w_lru_way;
            end
        end else if (w_hit_any) begin
            o_sel.hit = 1'b1;
            o_sel.wr  = 1'b1;
            o_way     = w_hit_way;
        end
        if (o_sel.wr) begin
            o_stamps[o_way] = i_clock;
            o_clock         = i_clock + 1'b1;
        end
        if (i_fill == lbc_pkg::REQ_FILL) begin
            o_valid[o_way] = 1'b1;
            o_tags[o_way]  = i_tag;
        end
    end

endmodule

`default_nettype wire
